@@ src/assert_macros.svh @@
// Assertion macros for the segment intersection unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Consequence checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/sip_pkg.sv @@
// Package with widths and transaction types of the segment intersection unit.
package sip_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int DETW = PW + 1;
    localparam int MAGW = DETW;
    localparam int NW   = DW + MAGW;
    localparam int NSW  = NW + FRAC_BITS;
    localparam int QB   = COORD_BITS + FRAC_BITS;
    localparam int RW   = NSW - QB;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } seg_t;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } pt_t;

endpackage

@@ src/segment_intersection_point_unit.sv @@
// Segment intersection unit: pipelined determinant, range test and divider.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+--------------------------------
//   seg     | seg_valid/seg_stall| two segments, integer endpoints
//   pt      | pt_valid/pt_stall  | hit flag and 16.16 point
//
// One transaction is accepted per cycle unless a stalled output holds the pipeline.
// The restoring divider decides one quotient bit per stage.
// The whole pipeline advances together; a stalled output freezes every stage.
// Reset clears only the valid bits of the stages.
`include "assert_macros.svh"

module segment_intersection_point_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_stall,
    input  sip_pkg::seg_t seg,
    output logic          pt_valid,
    input  logic          pt_stall,
    output sip_pkg::pt_t  pt
);
    import sip_pkg::*;

    logic adv;
    assign adv       = !pt_valid || !pt_stall;
    assign seg_stall = !adv;

    // Stage 1: differences.
    logic                         v1_reg;
    logic signed [DW-1:0]         dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg;
    // Stage 2: products.
    logic                         v2_reg;
    logic signed [PW-1:0]         p_det0_reg, p_det1_reg, p_sn0_reg, p_sn1_reg;
    logic signed [PW-1:0]         p_tn0_reg, p_tn1_reg;
    logic signed [DW-1:0]         dax2_reg, day2_reg;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg;
    // Stage 3: determinant and numerators.
    logic                         v3_reg;
    logic signed [DETW-1:0]       det_reg, sn_reg, tn_reg;
    logic signed [DW-1:0]         dax3_reg, day3_reg;
    logic signed [COORD_BITS-1:0] ax3_reg, ay3_reg;
    // Stage 4: range test and magnitudes.
    logic                         v4_reg, hit4_reg;
    logic [MAGW-1:0]              dmag4_reg, snmag4_reg;
    logic signed [DW-1:0]         dax4_reg, day4_reg;
    logic signed [COORD_BITS-1:0] ax4_reg, ay4_reg;
    // Divider stages, index 0 is loaded with the scaled numerators.
    logic [QB:0]                  dv_reg, dhit_reg;
    logic [RW-1:0]                rem_reg [0:QB][0:1];
    logic [QB-1:0]                quo_reg [0:QB][0:1];
    logic [MAGW-1:0]              dmag_reg [0:QB];
    logic [1:0]                   flip_reg [0:QB];
    logic signed [COORD_BITS-1:0] dax_s_reg [0:QB];
    logic signed [COORD_BITS-1:0] day_s_reg [0:QB];
    // Output register.
    logic                         pt_valid_reg;
    pt_t                          pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            dv_reg       <= '0;
            pt_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg       <= seg_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            dv_reg       <= {dv_reg[QB-1:0], v4_reg};
            pt_valid_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dax_reg <= DW'(seg.a_end_x) - DW'(seg.a_start_x);
            day_reg <= DW'(seg.a_end_y) - DW'(seg.a_start_y);
            dbx_reg <= DW'(seg.b_end_x) - DW'(seg.b_start_x);
            dby_reg <= DW'(seg.b_end_y) - DW'(seg.b_start_y);
            ex_reg  <= DW'(seg.b_start_x) - DW'(seg.a_start_x);
            ey_reg  <= DW'(seg.b_start_y) - DW'(seg.a_start_y);
            ax1_reg <= seg.a_start_x;
            ay1_reg <= seg.a_start_y;

            p_det0_reg <= PW'(dbx_reg) * PW'(day_reg);
            p_det1_reg <= PW'(dax_reg) * PW'(dby_reg);
            p_sn0_reg  <= PW'(dbx_reg) * PW'(ey_reg);
            p_sn1_reg  <= PW'(dby_reg) * PW'(ex_reg);
            p_tn0_reg  <= PW'(dax_reg) * PW'(ey_reg);
            p_tn1_reg  <= PW'(day_reg) * PW'(ex_reg);
            dax2_reg   <= dax_reg;
            day2_reg   <= day_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;

            det_reg  <= DETW'(p_det0_reg) - DETW'(p_det1_reg);
            sn_reg   <= DETW'(p_sn0_reg) - DETW'(p_sn1_reg);
            tn_reg   <= DETW'(p_tn0_reg) - DETW'(p_tn1_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // Range test: the numerators take the sign of the determinant, so that the
    // ratio lies in [0,1] exactly when 0 <= num <= |det|.
    logic signed [DETW:0] det_e, sn_e, tn_e, det_a, sn_a, tn_a, s_gap, t_gap;
    logic                 hit_next;

    always_comb
    begin
        det_e    = (DETW+1)'(det_reg);
        sn_e     = (DETW+1)'(sn_reg);
        tn_e     = (DETW+1)'(tn_reg);
        det_a    = det_reg[DETW-1] ? -det_e : det_e;
        sn_a     = det_reg[DETW-1] ? -sn_e  : sn_e;
        tn_a     = det_reg[DETW-1] ? -tn_e  : tn_e;
        s_gap    = det_a - sn_a;
        t_gap    = det_a - tn_a;
        hit_next = (det_reg != '0) && !sn_a[DETW] && !tn_a[DETW]
                   && !s_gap[DETW] && !t_gap[DETW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit4_reg   <= hit_next;
            dmag4_reg  <= MAGW'(det_a);
            snmag4_reg <= MAGW'(sn_a);
            dax4_reg   <= dax3_reg;
            day4_reg   <= day3_reg;
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
        end
    end

    // Scaled numerators |d| * sn * 2^FRAC_BITS; the quotient takes the sign of d.
    logic [DW-1:0]  dabs_x, dabs_y;
    logic [NW-1:0]  n_x, n_y;
    logic [NSW-1:0] ns_x, ns_y;

    always_comb
    begin
        dabs_x = dax4_reg[DW-1] ? DW'(-dax4_reg) : DW'(dax4_reg);
        dabs_y = day4_reg[DW-1] ? DW'(-day4_reg) : DW'(day4_reg);
        n_x    = NW'(dabs_x) * NW'(snmag4_reg);
        n_y    = NW'(dabs_y) * NW'(snmag4_reg);
        ns_x   = NSW'(n_x) << FRAC_BITS;
        ns_y   = NSW'(n_y) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0][0]  <= ns_x[NSW-1:QB];
            rem_reg[0][1]  <= ns_y[NSW-1:QB];
            quo_reg[0][0]  <= ns_x[QB-1:0];
            quo_reg[0][1]  <= ns_y[QB-1:0];
            dmag_reg[0]    <= dmag4_reg;
            flip_reg[0]    <= {day4_reg[DW-1], dax4_reg[DW-1]};
            dhit_reg[0]    <= hit4_reg;
            dax_s_reg[0]   <= ax4_reg;
            day_s_reg[0]   <= ay4_reg;
        end
    end

    // Restoring divider: each stage shifts in one numerator bit and decides
    // one quotient bit, which enters at the bottom of the same shift word.
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        for (genvar ln = 0; ln < 2; ln++)
        begin : g_lane
            logic [RW-1:0] r2;
            logic [RW:0]   diff;
            always_comb
            begin
                r2   = {rem_reg[k][ln][RW-2:0], quo_reg[k][ln][QB-1]};
                diff = {1'b0, r2} - (RW+1)'(dmag_reg[k]);
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k+1][ln] <= diff[RW] ? r2 : diff[RW-1:0];
                    quo_reg[k+1][ln] <= {quo_reg[k][ln][QB-2:0], !diff[RW]};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dmag_reg[k+1]  <= dmag_reg[k];
                flip_reg[k+1]  <= flip_reg[k];
                dhit_reg[k+1]  <= dhit_reg[k];
                dax_s_reg[k+1] <= dax_s_reg[k];
                day_s_reg[k+1] <= day_s_reg[k];
            end
        end
    end

    logic [OUT_BITS-1:0] qx, qy, bx, by;

    always_comb
    begin
        qx = OUT_BITS'(quo_reg[QB][0]);
        qy = OUT_BITS'(quo_reg[QB][1]);
        if (flip_reg[QB][0])
        begin
            qx = -qx;
        end
        if (flip_reg[QB][1])
        begin
            qy = -qy;
        end
        bx = OUT_BITS'(dax_s_reg[QB]) << FRAC_BITS;
        by = OUT_BITS'(day_s_reg[QB]) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg.hit     <= dhit_reg[QB];
            pt_reg.cross_x <= dhit_reg[QB] ? bx + qx : '0;
            pt_reg.cross_y <= dhit_reg[QB] ? by + qy : '0;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    `CHK_NEXT(a_seg_enters, clk, rst_n, seg_valid && !seg_stall, v1_reg)
    `CHK_IMPL(a_miss_zero, clk, rst_n, pt_valid && !pt.hit,
              pt.cross_x == '0 && pt.cross_y == '0)
    `CHK_NEXT(a_freeze, clk, rst_n, !adv, $stable(dv_reg) && $stable(v4_reg))

endmodule
